// ===== src/anre_pkg.sv =====
package anre_pkg;

    // Input operation codes
    typedef enum logic [3:0] {
        OP_TICK        = 4'd0,
        OP_START_NONCE = 4'd1,
        OP_START_AUTO  = 4'd2,
        OP_STOP        = 4'd3,
        OP_CLAIM_ACK   = 4'd4,
        OP_STOP_ACK    = 4'd5,
        OP_DENIED      = 4'd6,
        OP_CLEAR_START = 4'd7,
        OP_CLEAR_STOP  = 4'd8,
        OP_SET_UI      = 4'd9
    } t_op;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_SEND_START  = 3'd0,
        KIND_SEND_STOP   = 3'd1,
        KIND_HEARTBEAT   = 3'd2,
        KIND_START_ACKED = 3'd3,
        KIND_STOP_ACKED  = 3'd4,
        KIND_DENIED      = 3'd5
    } t_kind;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RETRY_INTERVAL = 2'd0,
        CFG_RETRY_LIMIT    = 2'd1,
        CFG_HB_PERIOD      = 2'd2
    } t_cfg_idx;

    localparam logic [15:0] RETRY_INTERVAL_RST = 16'd500;
    localparam logic [7:0]  RETRY_LIMIT_RST    = 8'd3;
    localparam logic [15:0] HB_PERIOD_RST      = 16'd2000;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [3:0]  operation;
        logic [15:0] nonce;
        logic [15:0] mover_id;
        logic [7:0]  ui_state;
        logic [15:0] advertised_nonce;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] frame_nonce;
        logic [15:0] acked_mover;
        logic [7:0]  reported_ui_state;
        logic [15:0] heartbeat_seq;
    } t_res;

    // All results caused by one input item, packed from slot 0 upward
    typedef struct packed {
        t_res [MAX_RESULTS-1:0] res;
        logic [1:0]             count;
        logic                   start_pending;
        logic                   stop_pending;
    } t_bundle;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] frame_nonce;
        logic [15:0] acked_mover;
        logic [7:0]  reported_ui_state;
        logic [15:0] heartbeat_seq;
        logic        start_pending;
        logic        stop_pending;
        logic        last_of_run;
    } t_out;

    function automatic logic [15:0] skip_zero_next(input logic [15:0] c);
        logic [15:0] n;
        n = c + 16'd1;
        return (n == 16'd0) ? 16'd1 : n;
    endfunction

endpackage

// ===== src/anre_front.sv =====
module anre_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  anre_pkg::t_in     i_in_data,
    input  logic              i_q_full,
    output logic              o_push,
    output anre_pkg::t_bundle o_bundle
);
    import anre_pkg::*;

    logic [15:0] r_interval;
    logic [7:0]  r_limit;
    logic [15:0] r_hb_period;

    logic [31:0] r_time,        n_time;
    logic [15:0] r_start_nonce, n_start_nonce;
    logic [31:0] r_start_time,  n_start_time;
    logic [7:0]  r_start_tries, n_start_tries;
    logic [15:0] r_stop_nonce,  n_stop_nonce;
    logic [31:0] r_stop_time,   n_stop_time;
    logic [7:0]  r_stop_tries,  n_stop_tries;
    logic [15:0] r_auto_cnt,    n_auto_cnt;
    logic [15:0] r_stop_cnt,    n_stop_cnt;
    logic [31:0] r_hb_time,     n_hb_time;
    logic [15:0] r_hb_cnt,      n_hb_cnt;
    logic [7:0]  r_adv_ui,      n_adv_ui;
    logic [15:0] r_adv_nonce,   n_adv_nonce;

    logic                   accept;
    logic [31:0]            time_inc;
    logic [31:0]            start_el;
    logic [31:0]            stop_el;
    logic [31:0]            hb_el;
    logic [15:0]            auto_next;
    logic [15:0]            stop_next;
    logic [15:0]            given_nonce;
    t_res [MAX_RESULTS-1:0] cand;
    logic [MAX_RESULTS-1:0] cand_v;
    t_bundle                bundle;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    assign time_inc    = r_time + 32'd1;
    assign start_el    = time_inc - r_start_time;
    assign stop_el     = time_inc - r_stop_time;
    assign hb_el       = time_inc - r_hb_time;
    assign auto_next   = skip_zero_next(r_auto_cnt);
    assign stop_next   = skip_zero_next(r_stop_cnt);
    assign given_nonce = (i_in_data.nonce == 16'd0) ? 16'd1 : i_in_data.nonce;

    always_comb begin
        n_time        = r_time;
        n_start_nonce = r_start_nonce;
        n_start_time  = r_start_time;
        n_start_tries = r_start_tries;
        n_stop_nonce  = r_stop_nonce;
        n_stop_time   = r_stop_time;
        n_stop_tries  = r_stop_tries;
        n_auto_cnt    = r_auto_cnt;
        n_stop_cnt    = r_stop_cnt;
        n_hb_time     = r_hb_time;
        n_hb_cnt      = r_hb_cnt;
        n_adv_ui      = r_adv_ui;
        n_adv_nonce   = r_adv_nonce;
        cand          = '0;
        cand_v        = '0;

        unique case (t_op'(i_in_data.operation))
            OP_TICK: begin
                n_time = time_inc;
                if ((r_start_nonce != 16'd0) && (start_el >= {16'd0, r_interval})
                        && (r_start_tries < r_limit)) begin
                    n_start_tries     = r_start_tries + 8'd1;
                    n_start_time      = time_inc;
                    cand_v[0]         = 1'b1;
                    cand[0].kind      = KIND_SEND_START;
                    cand[0].frame_nonce = r_start_nonce;
                end
                if ((r_stop_nonce != 16'd0) && (stop_el >= {16'd0, r_interval})
                        && (r_stop_tries < r_limit)) begin
                    n_stop_tries      = r_stop_tries + 8'd1;
                    n_stop_time       = time_inc;
                    cand_v[1]         = 1'b1;
                    cand[1].kind      = KIND_SEND_STOP;
                    cand[1].frame_nonce = r_stop_nonce;
                end
                if (hb_el >= {16'd0, r_hb_period}) begin
                    n_hb_time                 = time_inc;
                    n_hb_cnt                  = r_hb_cnt + 16'd1;
                    cand_v[2]                 = 1'b1;
                    cand[2].kind              = KIND_HEARTBEAT;
                    cand[2].frame_nonce       = r_adv_nonce;
                    cand[2].reported_ui_state = r_adv_ui;
                    cand[2].heartbeat_seq     = r_hb_cnt + 16'd1;
                end
            end
            OP_START_NONCE: begin
                n_start_nonce       = given_nonce;
                n_start_time        = r_time;
                n_start_tries       = 8'd1;
                cand_v[0]           = 1'b1;
                cand[0].kind        = KIND_SEND_START;
                cand[0].frame_nonce = given_nonce;
            end
            OP_START_AUTO: begin
                n_auto_cnt          = auto_next;
                n_start_nonce       = auto_next;
                n_start_time        = r_time;
                n_start_tries       = 8'd1;
                cand_v[0]           = 1'b1;
                cand[0].kind        = KIND_SEND_START;
                cand[0].frame_nonce = auto_next;
            end
            OP_STOP: begin
                n_stop_cnt          = stop_next;
                n_stop_nonce        = stop_next;
                n_stop_time         = r_time;
                n_stop_tries        = 8'd1;
                cand_v[0]           = 1'b1;
                cand[0].kind        = KIND_SEND_STOP;
                cand[0].frame_nonce = stop_next;
            end
            OP_CLAIM_ACK: begin
                if ((r_start_nonce != 16'd0) && (i_in_data.nonce == r_start_nonce)) begin
                    n_start_nonce       = 16'd0;
                    n_start_tries       = 8'd0;
                    cand_v[0]           = 1'b1;
                    cand[0].kind        = KIND_START_ACKED;
                    cand[0].frame_nonce = i_in_data.nonce;
                    cand[0].acked_mover = i_in_data.mover_id;
                end
            end
            OP_STOP_ACK: begin
                if ((r_stop_nonce != 16'd0) && (i_in_data.nonce == r_stop_nonce)) begin
                    n_stop_nonce        = 16'd0;
                    n_stop_tries        = 8'd0;
                    cand_v[0]           = 1'b1;
                    cand[0].kind        = KIND_STOP_ACKED;
                    cand[0].frame_nonce = i_in_data.nonce;
                end
            end
            OP_DENIED: begin
                n_start_nonce       = 16'd0;
                n_start_tries       = 8'd0;
                cand_v[0]           = 1'b1;
                cand[0].kind        = KIND_DENIED;
                cand[0].frame_nonce = r_start_nonce;
            end
            OP_CLEAR_START: begin
                n_start_nonce = 16'd0;
                n_start_tries = 8'd0;
            end
            OP_CLEAR_STOP: begin
                n_stop_nonce = 16'd0;
                n_stop_tries = 8'd0;
            end
            OP_SET_UI: begin
                n_adv_ui    = i_in_data.ui_state;
                n_adv_nonce = i_in_data.advertised_nonce;
            end
            default: begin
            end
        endcase
    end

    // Pack the produced results toward slot 0, keeping their order
    always_comb begin
        bundle = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (cand_v[i]) begin
                bundle.res[bundle.count] = cand[i];
                bundle.count             = bundle.count + 2'd1;
            end
        end
        bundle.start_pending = (n_start_nonce != 16'd0);
        bundle.stop_pending  = (n_stop_nonce != 16'd0);
    end

    assign o_bundle = bundle;
    assign o_push   = accept && (bundle.count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= RETRY_INTERVAL_RST;
            r_limit     <= RETRY_LIMIT_RST;
            r_hb_period <= HB_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RETRY_INTERVAL: r_interval  <= i_cfg_data;
                CFG_RETRY_LIMIT:    r_limit     <= i_cfg_data[7:0];
                CFG_HB_PERIOD:      r_hb_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time        <= '0;
            r_start_nonce <= '0;
            r_start_time  <= '0;
            r_start_tries <= '0;
            r_stop_nonce  <= '0;
            r_stop_time   <= '0;
            r_stop_tries  <= '0;
            r_auto_cnt    <= '0;
            r_stop_cnt    <= '0;
            r_hb_time     <= '0;
            r_hb_cnt      <= '0;
            r_adv_ui      <= '0;
            r_adv_nonce   <= '0;
        end else if (accept) begin
            r_time        <= n_time;
            r_start_nonce <= n_start_nonce;
            r_start_time  <= n_start_time;
            r_start_tries <= n_start_tries;
            r_stop_nonce  <= n_stop_nonce;
            r_stop_time   <= n_stop_time;
            r_stop_tries  <= n_stop_tries;
            r_auto_cnt    <= n_auto_cnt;
            r_stop_cnt    <= n_stop_cnt;
            r_hb_time     <= n_hb_time;
            r_hb_cnt      <= n_hb_cnt;
            r_adv_ui      <= n_adv_ui;
            r_adv_nonce   <= n_adv_nonce;
        end
    end

endmodule

// ===== src/anre_queue.sv =====
module anre_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  anre_pkg::t_bundle i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output anre_pkg::t_bundle o_pop_data,
    output logic              o_empty
);
    import anre_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_bundle       r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full     = (r_count == FULL_CNT);
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== src/anre_back.sv =====
module anre_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  anre_pkg::t_bundle i_bundle,
    input  logic              i_q_empty,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output anre_pkg::t_out    o_out_data
);
    import anre_pkg::*;

    t_bundle    r_bundle;
    logic       r_have;
    logic [1:0] r_idx;

    logic xfer;
    logic last;
    t_res cur;

    assign cur  = r_bundle.res[r_idx];
    assign last = (r_idx == (r_bundle.count - 2'd1));
    assign xfer = r_have && !i_out_stall;

    // Take the next bundle once the current one is fully delivered
    assign o_pop = !i_q_empty && (!r_have || (xfer && last));

    assign o_out_valid                  = r_have;
    assign o_out_data.kind              = cur.kind;
    assign o_out_data.frame_nonce       = cur.frame_nonce;
    assign o_out_data.acked_mover       = cur.acked_mover;
    assign o_out_data.reported_ui_state = cur.reported_ui_state;
    assign o_out_data.heartbeat_seq     = cur.heartbeat_seq;
    assign o_out_data.start_pending     = r_bundle.start_pending;
    assign o_out_data.stop_pending      = r_bundle.stop_pending;
    assign o_out_data.last_of_run       = last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bundle <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_have <= 1'b1;
            r_idx  <= '0;
        end else if (xfer) begin
            if (last) begin
                r_have <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

// ===== src/ack_nonce_retransmit_engine_core.sv =====
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-----------------------------
// input    | in        | i_in_valid / o_in_stall    | i_in_data  (anre_pkg::t_in)
// result   | out       | o_out_valid / i_out_stall  | o_out_data (anre_pkg::t_out)
// config   | in        | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// One input transfer per cycle while the result queue has room; the front
// updates all slot state in the cycle of the transfer.
// Results leave one per cycle unless i_out_stall holds them, so an item with k
// results gives k transfers; each is registered in the queue, then in the back.
// Reset (synchronous, active low) empties the queue, clears all slot state and
// loads the register defaults: interval 500, limit 3, heartbeat 2000.
// o_in_stall rises only while the queue is full; i_out_stall holds the result.
module ack_nonce_retransmit_engine_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  anre_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output anre_pkg::t_out o_out_data
);
    import anre_pkg::*;

    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    t_bundle push_bundle;
    t_bundle pop_bundle;

    // Front: accept, classify and update slot state; push one bundle per item with results
    anre_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_bundle   (push_bundle)
    );

    // Short queue decouples the two sides
    anre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (push_bundle),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (pop_bundle),
        .o_empty     (q_empty)
    );

    // Back: serialize each bundle into result transfers
    anre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bundle    (pop_bundle),
        .i_q_empty   (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("result queue overflow");

    // A run that is not finished keeps the output valid
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last_of_run) |=> o_out_valid)
        else $error("result run broken");

    // Heartbeat fields are zero on every other kind
    a_hb_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.kind != KIND_HEARTBEAT))
            |-> (o_out_data.heartbeat_seq == 16'd0
                 && o_out_data.reported_ui_state == 8'd0))
        else $error("heartbeat fields set on non-heartbeat result");

    // Mover is reported only with a start acknowledge
    a_mover_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.kind != KIND_START_ACKED))
            |-> (o_out_data.acked_mover == 16'd0))
        else $error("mover set on non-ack result");

endmodule

// ===== sim/ack_nonce_retransmit_engine_core_test.sv =====
module ack_nonce_retransmit_engine_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import anre_pkg::*;

    // Operation codes the block must ignore
    localparam logic [3:0] OP_FIRST_UNUSED = 4'd10;
    localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;

    // Margin to let the pipeline settle after the last owed frame
    localparam int SETTLE_CYCLES = 6;
    // Cycles without any transfer before the run is declared hung
    localparam int STUCK_LIMIT   = 2000;

    // How a directed row is checked: by the predictor, or against a typed value
    typedef enum logic [1:0] {
        FROM_MODEL,
        TYPED_NONE,
        TYPED_ONE
    } t_check_mode;

    typedef struct {
        t_in         stim;
        t_check_mode mode;
        t_out        want;
    } t_row;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    t_cfg_idx   cfg_idx   = CFG_RETRY_INTERVAL;
    logic [15:0] cfg_data = 16'd0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in        in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out       out_data;

    int send_idle_pct = 0;
    int rcv_idle_pct  = 0;
    int fail_count    = 0;
    int stuck_cycles  = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    ack_nonce_retransmit_engine_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // Predictor: own copy of the registers and the slot state
    // ------------------------------------------------------------------
    logic [15:0] gap_ms       = RETRY_INTERVAL_RST;
    logic [7:0]  max_attempts = RETRY_LIMIT_RST;
    logic [15:0] hb_every     = HB_PERIOD_RST;

    logic [31:0] ms_now           = '0;
    logic [15:0] start_nonce_held = '0;
    logic [31:0] start_sent_at    = '0;
    logic [7:0]  start_attempts   = '0;
    logic [15:0] stop_nonce_held  = '0;
    logic [31:0] stop_sent_at     = '0;
    logic [7:0]  stop_attempts    = '0;
    logic [15:0] auto_seq         = '0;
    logic [15:0] stop_seq         = '0;
    logic [31:0] hb_last_at       = '0;
    logic [15:0] hb_count         = '0;
    logic [7:0]  ui_advert        = '0;
    logic [15:0] nonce_advert     = '0;

    // Frames still owed by the block, oldest first
    t_out expected_frames [$];

    function automatic t_out make_frame(input t_kind k, input logic [15:0] fnonce,
                                        input logic [15:0] mover, input logic [7:0] ui,
                                        input logic [15:0] seq);
        t_out f;
        f = '0;
        f.kind              = k;
        f.frame_nonce       = fnonce;
        f.acked_mover       = mover;
        f.reported_ui_state = ui;
        f.heartbeat_seq     = seq;
        return f;
    endfunction

    // Advance the slot state by one input item; return the frames it causes
    function automatic int advance_engine(input t_in it, output t_out res [MAX_RESULTS]);
        int n;
        int i;
        n = 0;
        res = '{default: '0};
        case (it.operation)
            OP_TICK: begin
                ms_now = ms_now + 32'd1;
                if (start_nonce_held != 16'd0 && ms_now - start_sent_at >= {16'd0, gap_ms}
                    && start_attempts < max_attempts) begin
                    start_attempts = start_attempts + 8'd1;
                    start_sent_at  = ms_now;
                    res[n] = make_frame(KIND_SEND_START, start_nonce_held, '0, '0, '0);
                    n++;
                end
                if (stop_nonce_held != 16'd0 && ms_now - stop_sent_at >= {16'd0, gap_ms}
                    && stop_attempts < max_attempts) begin
                    stop_attempts = stop_attempts + 8'd1;
                    stop_sent_at  = ms_now;
                    res[n] = make_frame(KIND_SEND_STOP, stop_nonce_held, '0, '0, '0);
                    n++;
                end
                if (ms_now - hb_last_at >= {16'd0, hb_every}) begin
                    hb_last_at = ms_now;
                    hb_count   = hb_count + 16'd1;
                    res[n] = make_frame(KIND_HEARTBEAT, nonce_advert, '0, ui_advert, hb_count);
                    n++;
                end
            end
            OP_START_NONCE, OP_START_AUTO: begin
                if (it.operation == OP_START_AUTO) begin
                    auto_seq = (auto_seq == 16'hFFFF) ? 16'd1 : auto_seq + 16'd1;
                    start_nonce_held = auto_seq;
                end else begin
                    start_nonce_held = (it.nonce == 16'd0) ? 16'd1 : it.nonce;
                end
                start_sent_at  = ms_now;
                start_attempts = 8'd1;
                res[n] = make_frame(KIND_SEND_START, start_nonce_held, '0, '0, '0);
                n++;
            end
            OP_STOP: begin
                stop_seq        = (stop_seq == 16'hFFFF) ? 16'd1 : stop_seq + 16'd1;
                stop_nonce_held = stop_seq;
                stop_sent_at    = ms_now;
                stop_attempts   = 8'd1;
                res[n] = make_frame(KIND_SEND_STOP, stop_nonce_held, '0, '0, '0);
                n++;
            end
            OP_CLAIM_ACK: begin
                // Drop stale acks: idle slot or another nonce
                if (start_nonce_held != 16'd0 && it.nonce == start_nonce_held) begin
                    start_nonce_held = '0;
                    start_attempts   = '0;
                    res[n] = make_frame(KIND_START_ACKED, it.nonce, it.mover_id, '0, '0);
                    n++;
                end
            end
            OP_STOP_ACK: begin
                if (stop_nonce_held != 16'd0 && it.nonce == stop_nonce_held) begin
                    stop_nonce_held = '0;
                    stop_attempts   = '0;
                    res[n] = make_frame(KIND_STOP_ACKED, it.nonce, '0, '0, '0);
                    n++;
                end
            end
            OP_DENIED: begin
                // Report even with no start pending
                res[n] = make_frame(KIND_DENIED, start_nonce_held, '0, '0, '0);
                n++;
                start_nonce_held = '0;
                start_attempts   = '0;
            end
            OP_CLEAR_START: begin
                start_nonce_held = '0;
                start_attempts   = '0;
            end
            OP_CLEAR_STOP: begin
                stop_nonce_held = '0;
                stop_attempts   = '0;
            end
            OP_SET_UI: begin
                ui_advert    = it.ui_state;
                nonce_advert = it.advertised_nonce;
            end
            default: ;
        endcase
        // Occupancy flags reflect the state after the whole item
        for (i = 0; i < n; i++) begin
            res[i].start_pending = (start_nonce_held != 16'd0);
            res[i].stop_pending  = (stop_nonce_held != 16'd0);
            res[i].last_of_run   = (i == n - 1);
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Directed table, run at the reset register values
    // ------------------------------------------------------------------
    t_row plan [24] = '{
        // claim denied with nothing pending reports nonce zero
        '{'{OP_DENIED, 16'h0000, 16'h0000, 8'h00, 16'h0000}, TYPED_ONE,
          '{KIND_DENIED, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1}},
        // acks against idle slots
        '{'{OP_CLAIM_ACK, 16'h0000, 16'hFFFF, 8'h00, 16'h0000}, TYPED_NONE, '0},
        '{'{OP_STOP_ACK, 16'h0000, 16'h0000, 8'h00, 16'h0000}, TYPED_NONE, '0},
        // zero start nonce becomes one
        '{'{OP_START_NONCE, 16'h0000, 16'h0000, 8'h00, 16'h0000}, TYPED_ONE,
          '{KIND_SEND_START, 16'h0001, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b1}},
        '{'{OP_CLAIM_ACK, 16'h0002, 16'h1234, 8'h00, 16'h0000}, TYPED_NONE, '0},
        '{'{OP_CLAIM_ACK, 16'h0001, 16'hFFFF, 8'h00, 16'h0000}, TYPED_ONE,
          '{KIND_START_ACKED, 16'h0001, 16'hFFFF, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1}},
        '{'{OP_START_NONCE, 16'hFFFF, 16'h0000, 8'h00, 16'h0000}, TYPED_ONE,
          '{KIND_SEND_START, 16'hFFFF, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b1}},
        '{'{OP_STOP, 16'h0000, 16'h0000, 8'h00, 16'h0000}, TYPED_ONE,
          '{KIND_SEND_STOP, 16'h0001, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b1, 1'b1}},
        '{'{OP_TICK, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF}, FROM_MODEL, '0},
        '{'{OP_STOP_ACK, 16'hFFFF, 16'h0000, 8'h00, 16'h0000}, TYPED_NONE, '0},
        '{'{OP_STOP_ACK, 16'h0001, 16'h0000, 8'h00, 16'h0000}, TYPED_ONE,
          '{KIND_STOP_ACKED, 16'h0001, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b1}},
        '{'{OP_DENIED, 16'h0000, 16'h0000, 8'h00, 16'h0000}, TYPED_ONE,
          '{KIND_DENIED, 16'hFFFF, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1}},
        '{'{OP_START_AUTO, 16'h0000, 16'h0000, 8'h00, 16'h0000}, TYPED_ONE,
          '{KIND_SEND_START, 16'h0001, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b1}},
        '{'{OP_START_AUTO, 16'h7777, 16'h0000, 8'h00, 16'h0000}, TYPED_ONE,
          '{KIND_SEND_START, 16'h0002, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b1}},
        '{'{OP_CLEAR_START, 16'h0000, 16'h0000, 8'h00, 16'h0000}, TYPED_NONE, '0},
        '{'{OP_STOP, 16'h0000, 16'h0000, 8'h00, 16'h0000}, TYPED_ONE,
          '{KIND_SEND_STOP, 16'h0002, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1}},
        '{'{OP_CLEAR_STOP, 16'h0000, 16'h0000, 8'h00, 16'h0000}, TYPED_NONE, '0},
        '{'{OP_SET_UI, 16'h0000, 16'h0000, 8'hFF, 16'hFFFF}, TYPED_NONE, '0},
        // unused codes change nothing
        '{'{OP_LAST_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF}, TYPED_NONE, '0},
        '{'{OP_FIRST_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF}, TYPED_NONE, '0},
        '{'{OP_START_NONCE, 16'h8001, 16'h0000, 8'h00, 16'h0000}, TYPED_ONE,
          '{KIND_SEND_START, 16'h8001, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b1}},
        '{'{OP_TICK, 16'h0000, 16'h0000, 8'h00, 16'h0000}, FROM_MODEL, '0},
        '{'{OP_CLEAR_START, 16'h0000, 16'h0000, 8'h00, 16'h0000}, TYPED_NONE, '0},
        '{'{OP_SET_UI, 16'h0000, 16'h0000, 8'h00, 16'h0000}, TYPED_NONE, '0}
    };

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Present one item, hold it until the transfer, then record what it owes.
    // Valid stays high on return so back-to-back items need no second assignment.
    task automatic send_item(input t_in item, input t_check_mode mode, input t_out want);
        t_out owed [MAX_RESULTS];
        int n;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        n = advance_engine(item, owed);
        case (mode)
            TYPED_NONE: ;
            TYPED_ONE:  expected_frames.push_back(want);
            default: begin
                for (int i = 0; i < n; i++) expected_frames.push_back(owed[i]);
            end
        endcase
    endtask

    // Drop valid, wait for every owed frame, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers on consecutive edges; the block must be idle
    task automatic write_config(input logic [15:0] gap, input logic [7:0] limit,
                                input logic [15:0] period);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_RETRY_INTERVAL;
        cfg_data <= gap;
        @(posedge clk);
        cfg_idx  <= CFG_RETRY_LIMIT;
        cfg_data <= {8'd0, limit};
        @(posedge clk);
        cfg_idx  <= CFG_HB_PERIOD;
        cfg_data <= period;
        @(posedge clk);
        cfg_we   <= 1'b0;
        gap_ms       = gap;
        max_attempts = limit;
        hb_every     = period;
    endtask

    // Mostly well-formed traffic: acks usually echo the pending nonce so slots
    // really clear; other acks are stale, and clears and ignored codes are mixed in.
    function automatic t_in pick_item();
        t_in it;
        int roll;
        it.operation        = 4'($urandom);
        it.nonce            = 16'($urandom);
        it.mover_id         = 16'($urandom);
        it.ui_state         = 8'($urandom);
        it.advertised_nonce = 16'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            it.operation = OP_TICK;
        end else if (roll < 45) begin
            it.operation = OP_START_NONCE;
            if ($urandom_range(0, 9) == 0) it.nonce = '0;
        end else if (roll < 52) begin
            it.operation = OP_START_AUTO;
        end else if (roll < 62) begin
            it.operation = OP_STOP;
        end else if (roll < 74) begin
            it.operation = OP_CLAIM_ACK;
            if ($urandom_range(0, 3) != 0) it.nonce = start_nonce_held;
        end else if (roll < 84) begin
            it.operation = OP_STOP_ACK;
            if ($urandom_range(0, 3) != 0) it.nonce = stop_nonce_held;
        end else if (roll < 88) begin
            it.operation = OP_DENIED;
        end else if (roll < 91) begin
            it.operation = OP_CLEAR_START;
        end else if (roll < 94) begin
            it.operation = OP_CLEAR_STOP;
        end else if (roll < 97) begin
            it.operation = OP_SET_UI;
        end else begin
            it.operation = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        end
        return it;
    endfunction

    // Random burst; at pause_at the sender holds off until nothing is owed
    task automatic run_random(input int count, input int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) drain();
            send_item(pick_item(), FROM_MODEL, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stall, and the frame checker
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    task automatic note_field(input string field, input logic [15:0] want_v,
                              input logic [15:0] got_v);
        if (got_v !== want_v) begin
            fail_count++;
            $display("%0t ns: %s expected %h got %h", $time, field, want_v, got_v);
        end
    endtask

    t_out want_frame;

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_frames.size() == 0) begin
                fail_count++;
                $display("%0t ns: expected no frame, got kind %0d nonce %h",
                         $time, out_data.kind, out_data.frame_nonce);
            end else begin
                want_frame = expected_frames.pop_front();
                note_field("kind", 16'(want_frame.kind), 16'(out_data.kind));
                note_field("frame_nonce", want_frame.frame_nonce, out_data.frame_nonce);
                note_field("acked_mover", want_frame.acked_mover, out_data.acked_mover);
                note_field("reported_ui_state", 16'(want_frame.reported_ui_state),
                           16'(out_data.reported_ui_state));
                note_field("heartbeat_seq", want_frame.heartbeat_seq, out_data.heartbeat_seq);
                note_field("start_pending", 16'(want_frame.start_pending),
                           16'(out_data.start_pending));
                note_field("stop_pending", 16'(want_frame.stop_pending),
                           16'(out_data.stop_pending));
                note_field("last_of_run", 16'(want_frame.last_of_run),
                           16'(out_data.last_of_run));
            end
        end
    end

    // Watchdog: count cycles in which neither channel transfers
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d frames owed",
                     $time, STUCK_LIMIT, expected_frames.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows at the reset register values
        send_idle_pct = 23;
        rcv_idle_pct  = 48;
        foreach (plan[k]) send_item(plan[k].stim, plan[k].mode, plan[k].want);
        drain();

        // Short interval and heartbeat period: resends and heartbeats stack up
        // to three frames per tick; hold off the sender once midway
        write_config(16'd2, 8'd3, 16'd5);
        run_random(70, 35);
        drain();

        // Zero interval and the largest limit: a pending slot resends every tick
        send_idle_pct = 48;
        rcv_idle_pct  = 23;
        write_config(16'd0, 8'd255, 16'hFFFF);
        run_random(60, -1);
        drain();

        // Zero limit never resends; heartbeat on every tick
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        write_config(16'hFFFF, 8'd0, 16'd1);
        run_random(50, -1);
        drain();

        // Limit of one never resends; zero period gives a heartbeat on every tick
        write_config(16'd1, 8'd1, 16'd0);
        run_random(30, -1);
        drain();

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/anre_pkg.sv
src/anre_front.sv
src/anre_queue.sv
src/anre_back.sv
src/ack_nonce_retransmit_engine_core.sv
sim/ack_nonce_retransmit_engine_core_test.sv
